// File: rtl/core/midi_note_off_scheduler_defines.svh
// ----------------------------------------------------------------------------
// midi_note_off_scheduler_defines
// Assertion macros for the note-off scheduler.
// ----------------------------------------------------------------------------
`ifndef MIDI_NOTE_OFF_SCHEDULER_DEFINES_SVH
`define MIDI_NOTE_OFF_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
// a holding in a cycle implies c in the same cycle
`define MNOS_ASSERT_IMPLY(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// a holding in a cycle implies c in the next cycle
`define MNOS_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define MNOS_ASSERT_IMPLY(label, clk, rst_n, a, c)
`define MNOS_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// File: rtl/core/mnos_pkg.sv
// ----------------------------------------------------------------------------
// mnos_pkg
// Shared types and constants of the MIDI note-off scheduler.
// ----------------------------------------------------------------------------
package mnos_pkg;

    localparam int MAX_PENDING = 32;
    localparam int IDX_W       = $clog2(MAX_PENDING);
    localparam int CNT_W       = $clog2(MAX_PENDING + 1);
    localparam int CMDQ_DEPTH  = 4;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

    localparam logic [1:0] REQ_TIME  = 2'd0;
    localparam logic [1:0] REQ_EVENT = 2'd1;
    localparam logic [1:0] REQ_STOP  = 2'd2;

    localparam logic [2:0] KIND_NOTE_DUR = 3'd0;
    localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
    localparam logic [2:0] KIND_NOTE_OFF = 3'd2;
    localparam logic [2:0] KIND_CONTROL  = 3'd3;
    localparam logic [2:0] KIND_PROGRAM  = 3'd4;

    localparam logic [2:0] MSG_NONE    = 3'd0;
    localparam logic [2:0] MSG_NOTE_ON = 3'd1;
    localparam logic [2:0] MSG_NOTE_OFF = 3'd2;
    localparam logic [2:0] MSG_CONTROL = 3'd3;
    localparam logic [2:0] MSG_PROGRAM = 3'd4;

    typedef struct packed {
        logic        has_msg;
        logic [2:0]  msg;
        logic [3:0]  ch;
        logic [6:0]  d1;
        logic [6:0]  d2;
        logic        scan_time;
        logic        scan_stop;
        logic        append;
        logic [23:0] t;
        logic [24:0] due;
    } cmd_t;

    typedef struct packed {
        logic [24:0] due;
        logic [3:0]  ch;
        logic [6:0]  pitch;
    } entry_t;

    typedef struct packed {
        logic [2:0]  msg_kind;
        logic [3:0]  ch;
        logic [6:0]  d1;
        logic [6:0]  d2;
        logic        last;
        logic        pending_valid;
        logic [24:0] next_off_time;
    } result_t;

endpackage

// File: rtl/core/mnos_front.sv
// ----------------------------------------------------------------------------
// mnos_front
// Classifies an incoming item into a command for the table sequencer.
// ----------------------------------------------------------------------------
module mnos_front (
    input  logic [1:0]    req_type,
    input  logic [23:0]   time_ms,
    input  logic [2:0]    kind,
    input  logic [3:0]    channel,
    input  logic [6:0]    data1,
    input  logic [6:0]    data2,
    input  logic [23:0]   note_len,
    output mnos_pkg::cmd_t cmd
);

    always_comb
    begin
        cmd           = '0;
        cmd.ch        = channel;
        cmd.d1        = data1;
        cmd.t         = time_ms;
        cmd.due       = {1'b0, time_ms} + {1'b0, note_len};
        unique case (req_type)
            mnos_pkg::REQ_TIME:
            begin
                cmd.scan_time = 1'b1;
            end
            mnos_pkg::REQ_EVENT:
            begin
                unique case (kind)
                    mnos_pkg::KIND_NOTE_DUR:
                    begin
                        cmd.has_msg = 1'b1;
                        cmd.msg     = mnos_pkg::MSG_NOTE_ON;
                        cmd.d2      = data2;
                        cmd.append  = (note_len != '0);
                    end
                    mnos_pkg::KIND_NOTE_ON:
                    begin
                        cmd.has_msg = 1'b1;
                        cmd.msg     = mnos_pkg::MSG_NOTE_ON;
                        cmd.d2      = data2;
                    end
                    mnos_pkg::KIND_NOTE_OFF:
                    begin
                        cmd.has_msg = 1'b1;
                        cmd.msg     = mnos_pkg::MSG_NOTE_OFF;
                    end
                    mnos_pkg::KIND_CONTROL:
                    begin
                        cmd.has_msg = 1'b1;
                        cmd.msg     = mnos_pkg::MSG_CONTROL;
                        cmd.d2      = data2;
                    end
                    mnos_pkg::KIND_PROGRAM:
                    begin
                        cmd.has_msg = 1'b1;
                        cmd.msg     = mnos_pkg::MSG_PROGRAM;
                    end
                    default:
                    begin
                        // tempo and unknown kinds: status only
                        cmd.has_msg = 1'b0;
                    end
                endcase
            end
            mnos_pkg::REQ_STOP:
            begin
                cmd.scan_stop = 1'b1;
            end
            default:
            begin
                cmd.has_msg = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/core/mnos_cmd_fifo.sv
// ----------------------------------------------------------------------------
// mnos_cmd_fifo
// Short command queue between the classifier and the table sequencer.
// ----------------------------------------------------------------------------
module mnos_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  mnos_pkg::cmd_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output mnos_pkg::cmd_t rd_data,
    output logic           empty
);

    mnos_pkg::cmd_t                     slots_reg [mnos_pkg::CMDQ_DEPTH];
    logic [mnos_pkg::CMDQ_PTR_W-1:0]    wptr_reg, wptr_next;
    logic [mnos_pkg::CMDQ_PTR_W-1:0]    rptr_reg, rptr_next;
    logic [mnos_pkg::CMDQ_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                               do_wr, do_rd;

    assign full    = (cnt_reg == mnos_pkg::CMDQ_CNT_W'(mnos_pkg::CMDQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slots_reg[rptr_reg];

    always_comb
    begin
        wptr_next = do_wr ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = do_rd ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/core/mnos_back.sv
// ----------------------------------------------------------------------------
// mnos_back
// Table sequencer: sends any message, compacts the pending table in one
// pass releasing note-offs, appends any new entry, reports status.
// ----------------------------------------------------------------------------
`include "midi_note_off_scheduler_defines.svh"

module mnos_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_empty,
    input  mnos_pkg::cmd_t    cmd_in,
    output logic              cmd_pop,
    output mnos_pkg::result_t res,
    output logic              res_valid,
    input  logic              res_pop
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MSG    = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_APPEND = 5'b01000,
        ST_STAT   = 5'b10000
    } state_t;

    state_t                       state_reg, state_next;
    mnos_pkg::cmd_t               cmd_reg, cmd_next;
    logic [mnos_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [mnos_pkg::CNT_W-1:0]   i_reg, i_next;
    logic [mnos_pkg::CNT_W-1:0]   w_reg, w_next;
    logic [24:0]                  best_reg, best_next;
    logic                         drop_first_reg, drop_first_next;
    mnos_pkg::result_t            res_reg, res_next;
    logic                         rv_reg, rv_next;

    mnos_pkg::entry_t             mem [mnos_pkg::MAX_PENDING];
    mnos_pkg::entry_t             rdata_reg;
    logic [mnos_pkg::IDX_W-1:0]   rd_addr;
    logic [mnos_pkg::IDX_W-1:0]   wr_addr;
    mnos_pkg::entry_t             wr_data;
    logic                         wr_en;

    logic                         slot_free;
    logic                         drop;
    logic [mnos_pkg::CNT_W-1:0]   i_inc;

    assign slot_free = !rv_reg || res_pop;
    assign res       = res_reg;
    assign res_valid = rv_reg;
    assign i_inc     = i_reg + 1'b1;

    assign drop = cmd_reg.scan_stop
               || (cmd_reg.scan_time && (rdata_reg.due <= {1'b0, cmd_reg.t}))
               || (drop_first_reg && (i_reg == '0));

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        cnt_next        = cnt_reg;
        i_next          = i_reg;
        w_next          = w_reg;
        best_next       = best_reg;
        drop_first_next = drop_first_reg;
        res_next        = res_reg;
        rv_next         = rv_reg && !res_pop;
        cmd_pop         = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = w_reg[mnos_pkg::IDX_W-1:0];
        wr_data         = rdata_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd_in;
                    state_next = ST_MSG;
                end
            end
            ST_MSG:
            begin
                if (!cmd_reg.has_msg || slot_free)
                begin
                    if (cmd_reg.has_msg)
                    begin
                        res_next          = '0;
                        res_next.msg_kind = cmd_reg.msg;
                        res_next.ch       = cmd_reg.ch;
                        res_next.d1       = cmd_reg.d1;
                        res_next.d2       = cmd_reg.d2;
                        rv_next           = 1'b1;
                    end
                    i_next          = '0;
                    w_next          = '0;
                    best_next       = '0;
                    drop_first_next = cmd_reg.append
                        && (cnt_reg == mnos_pkg::CNT_W'(mnos_pkg::MAX_PENDING));
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                rd_addr = i_reg[mnos_pkg::IDX_W-1:0];
                if (i_reg == cnt_reg)
                begin
                    state_next = cmd_reg.append ? ST_APPEND : ST_STAT;
                end
                else if (drop)
                begin
                    if (slot_free)
                    begin
                        res_next          = '0;
                        res_next.msg_kind = mnos_pkg::MSG_NOTE_OFF;
                        res_next.ch       = rdata_reg.ch;
                        res_next.d1       = rdata_reg.pitch;
                        rv_next           = 1'b1;
                        i_next            = i_inc;
                        rd_addr           = i_inc[mnos_pkg::IDX_W-1:0];
                    end
                end
                else
                begin
                    // keep: move down to the write position
                    wr_en   = 1'b1;
                    w_next  = w_reg + 1'b1;
                    i_next  = i_inc;
                    rd_addr = i_inc[mnos_pkg::IDX_W-1:0];
                    if ((w_reg == '0) || (rdata_reg.due < best_reg))
                    begin
                        best_next = rdata_reg.due;
                    end
                end
            end
            ST_APPEND:
            begin
                wr_en         = 1'b1;
                wr_data.due   = cmd_reg.due;
                wr_data.ch    = cmd_reg.ch;
                wr_data.pitch = cmd_reg.d1;
                w_next        = w_reg + 1'b1;
                if ((w_reg == '0) || (cmd_reg.due < best_reg))
                begin
                    best_next = cmd_reg.due;
                end
                state_next = ST_STAT;
            end
            ST_STAT:
            begin
                if (slot_free)
                begin
                    res_next               = '0;
                    res_next.last          = 1'b1;
                    res_next.pending_valid = (w_reg != '0);
                    res_next.next_off_time = (w_reg != '0) ? best_reg : '0;
                    rv_next                = 1'b1;
                    cnt_next               = w_reg;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        i_reg          <= i_next;
        w_reg          <= w_next;
        best_reg       <= best_next;
        drop_first_reg <= drop_first_next;
        res_reg        <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    `MNOS_ASSERT_IMPLY(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= mnos_pkg::CNT_W'(mnos_pkg::MAX_PENDING))
    `MNOS_ASSERT_IMPLY(a_scan_order, clk, rst_n, state_reg == ST_SCAN, (w_reg <= i_reg) && (i_reg <= cnt_reg))
    `MNOS_ASSERT_NEXT(a_stat_count, clk, rst_n, (state_reg == ST_STAT) && slot_free, (cnt_reg == $past(w_reg)) && rv_reg && res_reg.last)

endmodule

// File: rtl/core/midi_note_off_scheduler.sv
// An accepted item waits in the command queue until the idle sequencer pops it; any
// message result is then registered, and the closing status follows the sequencer's
// pass over the pending table memory (one entry per cycle unless a due note-off waits
// for a free result slot) and any note-off append, before the next item is popped.
// A command queue of 4 lets items be accepted while the sequencer works.
// Reset (rst_n low, asynchronous) clears queues, pending count and FSM state only.
// ----------------------------------------------------------------------------
// midi_note_off_scheduler
// Dispatches MIDI events and schedules, expires and flushes pending note-offs.
// ----------------------------------------------------------------------------
module midi_note_off_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  req_type,
    input  logic [23:0] time_ms,
    input  logic [2:0]  kind,
    input  logic [3:0]  channel,
    input  logic [6:0]  data1,
    input  logic [6:0]  data2,
    input  logic [23:0] note_len,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  msg_kind,
    output logic [3:0]  out_channel,
    output logic [6:0]  out_data1,
    output logic [6:0]  out_data2,
    output logic        last,
    output logic        pending_valid,
    output logic [24:0] next_off_time
);

    mnos_pkg::cmd_t    cmd_w;
    mnos_pkg::cmd_t    q_data;
    logic              q_empty;
    logic              q_pop;
    mnos_pkg::result_t res;
    logic              res_valid;

    mnos_front u_front (
        .req_type    (req_type),
        .time_ms     (time_ms),
        .kind        (kind),
        .channel     (channel),
        .data1       (data1),
        .data2       (data2),
        .note_len    (note_len),
        .cmd         (cmd_w)
    );

    mnos_cmd_fifo u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cmd_w),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    mnos_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (q_empty),
        .cmd_in    (q_data),
        .cmd_pop   (q_pop),
        .res       (res),
        .res_valid (res_valid),
        .res_pop   (pop)
    );

    assign empty         = !res_valid;
    assign msg_kind      = res.msg_kind;
    assign out_channel   = res.ch;
    assign out_data1     = res.d1;
    assign out_data2     = res.d2;
    assign last          = res.last;
    assign pending_valid = res.pending_valid;
    assign next_off_time = res.next_off_time;

endmodule

// File: bench/tb_midi_note_off_scheduler.sv
// ----------------------------------------------------------------------------
// tb_midi_note_off_scheduler
// Drives event, time, stop and unused-type items into the note-off scheduler under random
// push and pop gaps, predicts every emitted message and closing status, and
// compares each popped result field by field in order.
// ----------------------------------------------------------------------------
module tb_midi_note_off_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  req;
        logic [23:0] t;
        logic [2:0]  knd;
        logic [3:0]  ch;
        logic [6:0]  d1;
        logic [6:0]  d2;
        logic [23:0] dur;
    } req_item_t;

    typedef struct {
        req_item_t   it;
        logic        typed;    // expected status typed in below
        logic        pv;
        logic [24:0] nt;
    } stim_row_t;

    localparam int         WATCHDOG     = 20000;
    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam logic [2:0] KIND_TEMPO   = 3'd5;
    localparam logic [2:0] KIND_UNUSED6 = 3'd6;
    localparam logic [2:0] KIND_UNUSED7 = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  req_type;
    logic [23:0] time_ms;
    logic [2:0]  kind;
    logic [3:0]  channel;
    logic [6:0]  data1;
    logic [6:0]  data2;
    logic [23:0] note_len;
    logic        empty;
    logic        pop;
    logic [2:0]  msg_kind;
    logic [3:0]  out_channel;
    logic [6:0]  out_data1;
    logic [6:0]  out_data2;
    logic        last;
    logic        pending_valid;
    logic [24:0] next_off_time;

    midi_note_off_scheduler dut (.*);

    mnos_pkg::entry_t  pend_q[$];
    mnos_pkg::result_t expected_msgs[$];
    int                errors;
    int                idle_cycles;
    bit                hold_pop;
    stim_row_t         rows[$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic mnos_pkg::result_t mk(logic [2:0] k, logic [3:0] c, logic [6:0] a,
                                             logic [6:0] b);
        mnos_pkg::result_t r;
        r = '0;
        r.msg_kind = k;
        r.ch = c;
        r.d1 = a;
        r.d2 = b;
        return r;
    endfunction

    // Update the pending note-off list and queue every result of one item.
    function automatic void schedule_item(req_item_t it, stim_row_t row);
        mnos_pkg::result_t st;
        mnos_pkg::entry_t  e;
        int                i;
        logic [24:0]       best;
        i = 0;
        best = '0;
        if (it.req == mnos_pkg::REQ_TIME)
        begin
            while (i < pend_q.size())
            begin
                if (pend_q[i].due <= {1'b0, it.t})
                begin
                    expected_msgs.push_back(mk(mnos_pkg::MSG_NOTE_OFF, pend_q[i].ch,
                                               pend_q[i].pitch, 7'd0));
                    pend_q.delete(i);
                end
                else
                    i++;
            end
        end
        else if (it.req == mnos_pkg::REQ_EVENT)
        begin
            case (it.knd)
                mnos_pkg::KIND_NOTE_DUR:
                begin
                    expected_msgs.push_back(mk(mnos_pkg::MSG_NOTE_ON, it.ch, it.d1, it.d2));
                    if (it.dur != '0)
                    begin
                        if (pend_q.size() >= mnos_pkg::MAX_PENDING)
                        begin
                            expected_msgs.push_back(mk(mnos_pkg::MSG_NOTE_OFF,
                                                       pend_q[0].ch, pend_q[0].pitch,
                                                       7'd0));
                            void'(pend_q.pop_front());
                        end
                        e.due   = {1'b0, it.t} + {1'b0, it.dur};
                        e.ch    = it.ch;
                        e.pitch = it.d1;
                        pend_q.push_back(e);
                    end
                end
                mnos_pkg::KIND_NOTE_ON:
                    expected_msgs.push_back(mk(mnos_pkg::MSG_NOTE_ON, it.ch, it.d1, it.d2));
                mnos_pkg::KIND_NOTE_OFF:
                    expected_msgs.push_back(mk(mnos_pkg::MSG_NOTE_OFF, it.ch, it.d1, 7'd0));
                mnos_pkg::KIND_CONTROL:
                    expected_msgs.push_back(mk(mnos_pkg::MSG_CONTROL, it.ch, it.d1, it.d2));
                mnos_pkg::KIND_PROGRAM:
                    expected_msgs.push_back(mk(mnos_pkg::MSG_PROGRAM, it.ch, it.d1, 7'd0));
                default: ;
            endcase
        end
        else if (it.req == mnos_pkg::REQ_STOP)
        begin
            while (pend_q.size() > 0)
            begin
                expected_msgs.push_back(mk(mnos_pkg::MSG_NOTE_OFF, pend_q[0].ch,
                                           pend_q[0].pitch, 7'd0));
                void'(pend_q.pop_front());
            end
        end
        foreach (pend_q[j])
            if (j == 0 || pend_q[j].due < best)
                best = pend_q[j].due;
        st = mk(mnos_pkg::MSG_NONE, 4'd0, 7'd0, 7'd0);
        st.last = 1'b1;
        st.pending_valid = pend_q.size() > 0;
        st.next_off_time = pend_q.size() > 0 ? best : 25'd0;
        if (row.typed && (st.pending_valid !== row.pv || st.next_off_time !== row.nt))
        begin
            $display("%0t: table row mismatch expected pv=%0d next=%0d actual pv=%0d next=%0d",
                     $time, row.pv, row.nt, st.pending_valid, st.next_off_time);
            errors++;
        end
        expected_msgs.push_back(st);
    endfunction

    function automatic req_item_t rand_item(bit wellformed);
        req_item_t it;
        int        sel;
        it.req = 2'($urandom_range(3, 0));
        it.t = 24'($urandom());
        it.knd = 3'($urandom_range(7, 0));
        it.ch = 4'($urandom());
        it.d1 = 7'($urandom());
        it.d2 = 7'($urandom());
        it.dur = 24'($urandom());
        if (wellformed)
        begin
            sel = $urandom_range(99, 0);
            it.req = sel < 75 ? mnos_pkg::REQ_EVENT
                   : (sel < 97 ? mnos_pkg::REQ_TIME : mnos_pkg::REQ_STOP);
            it.t = 24'($urandom_range(4000, 0));
            if ($urandom_range(9, 0) < 6)
                it.knd = mnos_pkg::KIND_NOTE_DUR;
            else
                it.knd = 3'($urandom_range(5, 1));
            if ($urandom_range(19, 0) != 0)
                it.dur = 24'($urandom_range(3000, 0));
        end
        return it;
    endfunction

    function automatic stim_row_t row_of(logic [1:0] r, logic [23:0] t, logic [2:0] k,
                                         logic [3:0] c, logic [6:0] a, logic [6:0] b,
                                         logic [23:0] d, logic typed, logic pv,
                                         logic [24:0] nt);
        stim_row_t s;
        s.it = '{req: r, t: t, knd: k, ch: c, d1: a, d2: b, dur: d};
        s.typed = typed;
        s.pv = pv;
        s.nt = nt;
        return s;
    endfunction

    // Offer one item until accepted, then optionally idle before the next.
    task automatic send_item(req_item_t it, stim_row_t row);
        int gap;
        push <= 1'b1;
        req_type <= it.req;
        time_ms <= it.t;
        kind <= it.knd;
        channel <= it.ch;
        data1 <= it.d1;
        data2 <= it.d2;
        note_len <= it.dur;
        @(posedge clk);
        while (full)
            @(posedge clk);
        schedule_item(it, row);
        gap = $urandom_range(9, 0) == 0 ? $urandom_range(40, 5) : $urandom_range(2, 0);
        if ($urandom_range(3, 0) == 0)
            gap = 0;
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Receiver: random pop with short gaps, a few long ones, or a long hold.
    initial
    begin
        int stall;
        pop = 1'b0;
        stall = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (stall == 0 && $urandom_range(49, 0) == 0)
                stall = $urandom_range(60, 20);
            if (hold_pop || stall != 0)
            begin
                pop <= 1'b0;
                if (stall != 0)
                    stall--;
            end
            else
                pop <= $urandom_range(3, 0) != 0;
        end
    end

    // Hold off popping for a long stretch so the command queue fills.
    initial
    begin
        hold_pop = 1'b0;
        wait (rst_n);
        repeat (600) @(posedge clk);
        hold_pop = 1'b1;
        repeat (400) @(posedge clk);
        hold_pop = 1'b0;
    end

    // Compare each popped result with the oldest expectation.
    always @(posedge clk)
    begin
        mnos_pkg::result_t exp_r;
        if (rst_n && pop && !empty)
        begin
            if (expected_msgs.size() == 0)
            begin
                $display("%0t: unexpected result kind=%0d", $time, msg_kind);
                errors++;
            end
            else
            begin
                exp_r = expected_msgs.pop_front();
                if (msg_kind !== exp_r.msg_kind || out_channel !== exp_r.ch ||
                    out_data1 !== exp_r.d1 || out_data2 !== exp_r.d2 ||
                    last !== exp_r.last || pending_valid !== exp_r.pending_valid ||
                    next_off_time !== exp_r.next_off_time)
                begin
                    $display("%0t: mismatch expected %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                             $time, exp_r.msg_kind, exp_r.ch, exp_r.d1, exp_r.d2,
                             exp_r.last, exp_r.pending_valid, exp_r.next_off_time);
                    $display("%0t:          actual   %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                             $time, msg_kind, out_channel, out_data1, out_data2,
                             last, pending_valid, next_off_time);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted item or result.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        req_item_t it;
        stim_row_t none;
        int        tail;
        errors = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        push = 1'b0;
        req_type = '0;
        time_ms = '0;
        kind = '0;
        channel = '0;
        data1 = '0;
        data2 = '0;
        note_len = '0;
        none = row_of(mnos_pkg::REQ_TIME, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0, '0);

        // directed table
        rows.push_back(row_of(mnos_pkg::REQ_TIME, 24'd0, '0, '0, '0, '0, '0,
                              1'b1, 1'b0, 25'd0));
        rows.push_back(row_of(mnos_pkg::REQ_STOP, 24'd0, '0, '0, '0, '0, '0,
                              1'b1, 1'b0, 25'd0));
        rows.push_back(row_of(mnos_pkg::REQ_EVENT, 24'hFFFFFF, mnos_pkg::KIND_NOTE_DUR,
                              4'd15, 7'd127, 7'd127, 24'hFFFFFF, 1'b1, 1'b1, 25'h1FFFFFE));
        rows.push_back(row_of(mnos_pkg::REQ_EVENT, 24'd100, mnos_pkg::KIND_NOTE_DUR,
                              4'd0, 7'd0, 7'd0, 24'd50, 1'b1, 1'b1, 25'd150));
        rows.push_back(row_of(mnos_pkg::REQ_EVENT, 24'd100, mnos_pkg::KIND_NOTE_DUR,
                              4'd3, 7'd60, 7'd90, 24'd50, 1'b1, 1'b1, 25'd150));
        rows.push_back(row_of(mnos_pkg::REQ_EVENT, 24'd0, mnos_pkg::KIND_NOTE_DUR,
                              4'd1, 7'd1, 7'd1, 24'd0, 1'b1, 1'b1, 25'd150));
        rows.push_back(row_of(mnos_pkg::REQ_EVENT, 24'd5, mnos_pkg::KIND_NOTE_ON,
                              4'd2, 7'd64, 7'd0, '0, 1'b0, 1'b0, '0));
        rows.push_back(row_of(mnos_pkg::REQ_EVENT, 24'd5, mnos_pkg::KIND_NOTE_OFF,
                              4'd2, 7'd64, 7'd99, '0, 1'b0, 1'b0, '0));
        rows.push_back(row_of(mnos_pkg::REQ_EVENT, 24'd5, mnos_pkg::KIND_CONTROL,
                              4'd9, 7'd7, 7'd127, '0, 1'b0, 1'b0, '0));
        rows.push_back(row_of(mnos_pkg::REQ_EVENT, 24'd5, mnos_pkg::KIND_PROGRAM,
                              4'd9, 7'd127, 7'd55, '0, 1'b0, 1'b0, '0));
        rows.push_back(row_of(mnos_pkg::REQ_EVENT, 24'd5, KIND_TEMPO, 4'd9, 7'd1, 7'd1,
                              24'd9, 1'b0, 1'b0, '0));
        rows.push_back(row_of(mnos_pkg::REQ_EVENT, 24'd5, KIND_UNUSED6, 4'd9, 7'd1, 7'd1,
                              24'd9, 1'b0, 1'b0, '0));
        rows.push_back(row_of(mnos_pkg::REQ_EVENT, 24'd5, KIND_UNUSED7, 4'd9, 7'd1, 7'd1,
                              24'd9, 1'b0, 1'b0, '0));
        rows.push_back(row_of(REQ_UNUSED, 24'd5, mnos_pkg::KIND_NOTE_DUR, 4'd9, 7'd1, 7'd1,
                              24'd9, 1'b0, 1'b0, '0));
        rows.push_back(row_of(mnos_pkg::REQ_TIME, 24'd149, '0, '0, '0, '0, '0,
                              1'b0, 1'b0, '0));
        rows.push_back(row_of(mnos_pkg::REQ_TIME, 24'd150, '0, '0, '0, '0, '0,
                              1'b1, 1'b1, 25'h1FFFFFE));
        rows.push_back(row_of(mnos_pkg::REQ_STOP, 24'd0, '0, '0, '0, '0, '0,
                              1'b1, 1'b0, 25'd0));
        // fill past the table size to displace the oldest entry
        for (int k = 0; k < 34; k++)
            rows.push_back(row_of(mnos_pkg::REQ_EVENT, 24'(k), mnos_pkg::KIND_NOTE_DUR,
                                  4'(k), 7'(k + 20), 7'd80, 24'd1000, 1'b0, 1'b0, '0));
        rows.push_back(row_of(mnos_pkg::REQ_TIME, 24'hFFFFFF, '0, '0, '0, '0, '0,
                              1'b1, 1'b0, 25'd0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[r])
            send_item(rows[r].it, rows[r]);

        for (int n = 0; n < 380; n++)
        begin
            // pause until everything drains once
            if (n == 180)
            begin
                push <= 1'b0;
                while (expected_msgs.size() != 0)
                    @(posedge clk);
            end
            it = rand_item($urandom_range(9, 0) != 0);
            send_item(it, none);
        end
        push <= 1'b0;

        while (expected_msgs.size() != 0)
            @(posedge clk);
        tail = 0;
        while (tail < 60)
        begin
            @(posedge clk);
            tail++;
        end
        if (errors == 0 && expected_msgs.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/mnos_pkg.sv
rtl/core/mnos_front.sv
rtl/core/mnos_cmd_fifo.sv
rtl/core/mnos_back.sv
rtl/core/midi_note_off_scheduler.sv
bench/tb_midi_note_off_scheduler.sv
